### hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define PT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication shorthand on top of the above.
`define PT_ASSERT_IMP(lbl, pre, post, msg) \
	`PT_ASSERT(lbl, (pre) |-> (post), msg)

`endif

### hw/rtl/pt_pkg.sv
`default_nettype none
package pt_pkg;

	localparam int MaxLen  = 256;
	localparam int SymBits = 8;
	localparam int NodeCap = MaxLen + 2;
	localparam int NodeW   = 9;
	localparam int PosW    = 8;
	localparam int ChildAw = NodeW + SymBits;
	localparam int ChildD  = NodeCap << SymBits;
	localparam logic [NodeW-1:0] HitMax = '1;

	typedef struct packed {
		logic [NodeW-1:0]   len;
		logic [NodeW-1:0]   link;
		logic [PosW-1:0]    start;
		logic [NodeW-1:0]   depth;
		logic [NodeW-1:0]   hits;
		logic [NodeW-1:0]   parent;
		logic [SymBits-1:0] chr;
	} node_t;

	localparam int NodeBits = $bits(node_t);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_WNODE = 10'b0000000010,
		S_WTXT = 10'b0000000100,
		S_WCMP = 10'b0000001000,
		S_CRD = 10'b0000010000,
		S_CCHK = 10'b0000100000,
		S_CVAL = 10'b0001000000,
		S_DRD = 10'b0010000000,
		S_FRD = 10'b0100000000,
		S_FRES = 10'b1000000000
	} state_t;

endpackage
`default_nettype wire

### hw/rtl/pt_in_if.sv
`default_nettype none
interface pt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       restart;

	modport source (output valid, output symbol, output restart, input ready);
	modport sink (input valid, input symbol, input restart, output ready);
endinterface
`default_nettype wire

### hw/rtl/pt_out_if.sv
`default_nettype none
interface pt_out_if;
	logic       valid;
	logic       ready;
	logic       new_node;
	logic [8:0] node_index;
	logic [8:0] pal_length;
	logic [7:0] pal_start;
	logic [8:0] suffix_node;
	logic [8:0] chain_depth;
	logic [8:0] occurrence_count;
	logic       overflow;

	modport source (output valid, output new_node, output node_index, output pal_length,
		output pal_start, output suffix_node, output chain_depth,
		output occurrence_count, output overflow, input ready);
	modport sink (input valid, input new_node, input node_index, input pal_length,
		input pal_start, input suffix_node, input chain_depth,
		input occurrence_count, input overflow, output ready);
endinterface
`default_nettype wire

### hw/rtl/pt_ram.sv
`default_nettype none
module pt_ram #(
	parameter int W = 8,
	parameter int D = 256,
	parameter int AW = $clog2(D)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/palindromic_tree_append.sv
// Palindromic tree (eertree) builder. Each input beat appends one symbol to the
// text and reports the longest palindromic suffix after it: its node, length,
// first start, suffix link, chain depth and hit count, plus flags for a newly
// created node and for a full text (256 symbols; further symbols are ignored).
// restart clears the tree before the symbol of that beat. One beat is handled
// at a time. Per symbol the block accepts the beat; then, for each node tested
// on each suffix-link walk, it reads the node, reads the text and compares (only
// the node step when the walk reaches the imaginary root); it checks the child
// after each walk, reads the link's depth for a new node whose link is a real
// node, and reads the result, waiting for the result register to free up; a
// symbol on a full text takes only the accept and the result read. The suffix-link
// walks, bounded by the single read port of the node memory, dominate the cost.
// The child table is not cleared on restart: an entry counts only if its node
// is below the node count and records the same parent and symbol, so restart
// takes effect at once. After reset a clearing pass writes zero to all 66048
// child entries, one per cycle, and the input is held off until it is done.
`default_nettype none
module palindromic_tree_append
	import pt_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	pt_in_if.sink      in_ch,
	pt_out_if.source   out_ch
);
	state_t state_q;

	// per-symbol context
	logic [SymBits-1:0] ch_q;
	logic [PosW-1:0]    pos_q;
	logic [NodeW-1:0]   cur_q;
	logic [NodeW-1:0]   cur_link_q;
	logic [9:0]         cur_len_q;     // signed, node 0 is -1
	logic               pneg_q;
	logic               walk2_q;
	logic [NodeW-1:0]   cand_q;
	logic [NodeW-1:0]   par_q;
	logic [9:0]         newlen_q;
	logic [PosW-1:0]    start_q;
	logic [NodeW-1:0]   lk_q;
	logic               new_q;
	logic               ovf_q;

	// tree state
	logic [NodeW-1:0] lsn_q;
	logic [NodeW-1:0] total_q;
	logic [8:0]       wp_q;

	// child table clearing pass after reset
	logic               clr_q;
	logic [ChildAw-1:0] clr_addr_q;

	// memory ports
	logic               txt_we, txt_re;
	logic [PosW-1:0]    txt_waddr, txt_raddr;
	logic [SymBits-1:0] txt_rdata;
	logic               node_we, node_re;
	logic [NodeW-1:0]   node_waddr, node_raddr;
	node_t              node_wdata, node_rd;
	logic [NodeBits-1:0] node_rbits;
	logic               child_we, child_re;
	logic [ChildAw-1:0] child_waddr, child_raddr;
	logic [NodeW-1:0]   child_wdata;
	logic [NodeW-1:0]   child_rdata;

	logic       accept;
	logic       restart_eff;
	logic [8:0] wp_eff;
	logic [NodeW-1:0] lsn_eff;
	logic [9:0] len_w;
	logic [10:0] p_w;
	logic       cand_ok;
	logic [NodeW-1:0] lk_w;
	logic       out_load;

	assign node_rd     = node_t'(node_rbits);
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && !clr_q;
	assign restart_eff = in_ch.restart;
	assign wp_eff      = restart_eff ? 9'd0 : wp_q;
	assign lsn_eff     = restart_eff ? 9'd1 : lsn_q;

	// length of the node under test; node 1 is the empty palindrome
	assign len_w = (cur_q == 9'd1) ? 10'd0 : {1'b0, node_rd.len};
	assign p_w   = {3'b000, pos_q} - 11'd1 - {len_w[9], len_w};

	// a child entry is live only if it was written in this run of the tree
	assign cand_ok = (cand_q >= 9'd2) && (cand_q < total_q) &&
		(node_rd.parent == cur_q) && (node_rd.chr == ch_q);
	assign lk_w = cand_ok ? cand_q : 9'd1;

	assign out_load = (state_q == S_FRES) && (!out_ch.valid || out_ch.ready);

	always_comb begin
		txt_we      = accept && !wp_eff[8];
		txt_waddr   = wp_eff[PosW-1:0];
		txt_re      = (state_q == S_WTXT);
		txt_raddr   = p_w[PosW-1:0];
		node_re     = 1'b0;
		node_raddr  = cur_q;
		node_we     = 1'b0;
		node_waddr  = total_q;
		node_wdata  = '{len: newlen_q[NodeW-1:0], link: 9'd1, start: start_q, depth: 9'd1,
			hits: 9'd1, parent: par_q, chr: ch_q};
		child_re    = (state_q == S_CRD);
		child_raddr = {cur_q, ch_q};
		child_we    = 1'b0;
		child_waddr = {cur_q, ch_q};
		child_wdata = total_q;
		unique case (state_q)
			S_WNODE: begin
				node_re    = (cur_q != 9'd0);
				node_raddr = cur_q;
			end
			S_CCHK: begin
				node_re    = 1'b1;
				node_raddr = child_rdata;
			end
			S_CVAL: begin
				if (!walk2_q) begin
					if (cand_ok) begin
						node_we    = 1'b1;
						node_waddr = cand_q;
						node_wdata = node_rd;
						if (node_rd.hits != HitMax) begin
							node_wdata.hits = node_rd.hits + 9'd1;
						end
					end else if (total_q < NodeW'(NodeCap)) begin
						child_we = 1'b1;
						if (cur_q == 9'd0) begin
							// single symbol palindrome links to the empty node
							node_we    = 1'b1;
							node_wdata = '{len: 9'd1, link: 9'd1,
								start: pos_q, depth: 9'd1,
								hits: 9'd1, parent: cur_q, chr: ch_q};
						end
					end
				end else if (lk_w < 9'd2) begin
					node_we         = 1'b1;
					node_wdata.link = lk_w;
				end else begin
					node_re    = 1'b1;
					node_raddr = lk_w;
				end
			end
			S_DRD: begin
				node_we          = 1'b1;
				node_wdata.link  = lk_q;
				node_wdata.depth = node_rd.depth + 9'd1;
			end
			S_FRD: begin
				node_re    = 1'b1;
				node_raddr = lsn_q;
			end
			default: begin
			end
		endcase
		// power-up contents of the child table are replaced by "no child"
		if (clr_q) begin
			child_we    = 1'b1;
			child_waddr = clr_addr_q;
			child_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ChildAw'(ChildD - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lsn_q        <= 9'd1;
			total_q      <= 9'd2;
			wp_q         <= 9'd0;
			out_ch.valid <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready && !out_load) begin
				out_ch.valid <= 1'b0;
			end
			if (node_we && node_waddr == total_q) begin
				total_q <= total_q + 9'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (restart_eff) begin
							total_q <= 9'd2;
							lsn_q   <= 9'd1;
						end
						ch_q    <= in_ch.symbol;
						new_q   <= 1'b0;
						walk2_q <= 1'b0;
						cur_q   <= lsn_eff;
						pos_q   <= wp_eff[PosW-1:0];
						if (wp_eff[8]) begin
							ovf_q   <= 1'b1;
							wp_q    <= wp_eff;
							state_q <= S_FRD;
						end else begin
							ovf_q   <= 1'b0;
							wp_q    <= wp_eff + 9'd1;
							state_q <= S_WNODE;
						end
					end
				end
				S_WNODE: begin
					if (cur_q == 9'd0) begin
						cur_len_q <= 10'h3FF;
						state_q   <= S_CRD;
					end else begin
						state_q <= S_WTXT;
					end
				end
				S_WTXT: begin
					cur_len_q  <= len_w;
					cur_link_q <= (cur_q == 9'd1) ? 9'd0 : node_rd.link;
					pneg_q     <= p_w[10];
					state_q    <= S_WCMP;
				end
				S_WCMP: begin
					if (!pneg_q && txt_rdata == ch_q) begin
						state_q <= S_CRD;
					end else begin
						cur_q   <= cur_link_q;
						state_q <= S_WNODE;
					end
				end
				S_CRD: state_q <= S_CCHK;
				S_CCHK: begin
					cand_q  <= child_rdata;
					state_q <= S_CVAL;
				end
				S_CVAL: begin
					if (!walk2_q) begin
						if (cand_ok) begin
							lsn_q   <= cand_q;
							state_q <= S_FRD;
						end else if (total_q < NodeW'(NodeCap)) begin
							new_q    <= 1'b1;
							lsn_q    <= total_q;
							par_q    <= cur_q;
							newlen_q <= cur_len_q + 10'd2;
							start_q  <= pos_q - PosW'(cur_len_q + 10'd2) + 8'd1;
							if (cur_q == 9'd0) begin
								state_q <= S_FRD;
							end else begin
								walk2_q <= 1'b1;
								cur_q   <= cur_link_q;
								state_q <= S_WNODE;
							end
						end else begin
							state_q <= S_FRD;
						end
					end else begin
						lk_q    <= lk_w;
						state_q <= (lk_w < 9'd2) ? S_FRD : S_DRD;
					end
				end
				S_DRD: state_q <= S_FRD;
				S_FRD: state_q <= S_FRES;
				S_FRES: begin
					if (out_load) begin
						out_ch.valid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.new_node   <= new_q;
			out_ch.overflow   <= ovf_q;
			out_ch.node_index <= lsn_q;
			if (lsn_q < 9'd2) begin
				out_ch.pal_length       <= 9'd0;
				out_ch.pal_start        <= 8'd0;
				out_ch.suffix_node      <= 9'd0;
				out_ch.chain_depth      <= 9'd0;
				out_ch.occurrence_count <= 9'd0;
			end else begin
				out_ch.pal_length       <= node_rd.len;
				out_ch.pal_start        <= node_rd.start;
				out_ch.suffix_node      <= node_rd.link;
				out_ch.chain_depth      <= node_rd.depth;
				out_ch.occurrence_count <= node_rd.hits;
			end
		end
	end

	pt_ram #(.W(SymBits), .D(MaxLen), .AW(PosW)) u_text (
		.clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(in_ch.symbol),
		.re(txt_re), .raddr(txt_raddr), .rdata(txt_rdata)
	);

	pt_ram #(.W(NodeBits), .D(NodeCap), .AW(NodeW)) u_node (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.re(node_re), .raddr(node_raddr), .rdata(node_rbits)
	);

	pt_ram #(.W(NodeW), .D(ChildD), .AW(ChildAw)) u_child (
		.clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
		.re(child_re), .raddr(child_raddr), .rdata(child_rdata)
	);
endmodule
`default_nettype wire

### hw/rtl/pt_chk.sv
`default_nettype none
`include "assert_macros.svh"
module pt_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       new_node,
	input wire logic       overflow,
	input wire logic [8:0] occurrence_count
);
	`PT_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 out_valid, "result beat dropped")
	`PT_ASSERT_IMP(a_busy, in_valid && in_ready, ##1 !in_ready, "second symbol taken while busy")
	`PT_ASSERT_IMP(a_new_ovf, out_valid, !(new_node && overflow), "new node on full text")
	`PT_ASSERT_IMP(a_new_hits, out_valid && new_node, occurrence_count == 9'd1,
		"new node count not one")
endmodule

bind palindromic_tree_append pt_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.new_node(out_ch.new_node), .overflow(out_ch.overflow),
	.occurrence_count(out_ch.occurrence_count)
);
`default_nettype wire
